/* rtl/servo_linear_interpolator_macros.svh */
// Assertion macros shared by the servo interpolator RTL.
`ifndef SERVO_LINEAR_INTERPOLATOR_MACROS_SVH
`define SERVO_LINEAR_INTERPOLATOR_MACROS_SVH

// Whenever ante holds at a clock edge outside reset, cons holds at that same edge.
`define SLI_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Whenever ante holds at a clock edge outside reset, cons holds at the next edge.
`define SLI_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/sli_pkg.sv */
// Types and constants shared by the servo linear interpolator.
package sli_pkg;

    localparam int NUM_SERVOS = 16;
    localparam int SERVO_AW   = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
    localparam int POS_W      = 16;
    localparam int DUR_W      = 16;
    localparam int ELAPSED_W  = 17;
    localparam int PERIOD_W   = 10;
    localparam int FRAC_W     = 16;
    localparam int IDX_W      = 4;
    localparam int PADDR_W    = 3;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(20);

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_TICK  = 2'd2,
        OP_ABORT = 2'd3
    } t_op;

    typedef struct packed {
        t_op                operation;
        logic [IDX_W-1:0]   servo_index;
        logic [POS_W-1:0]   start_pos;
        logic [POS_W-1:0]   target_pos;
        logic [DUR_W-1:0]   move_duration;
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0]   servo_number;
        logic [POS_W-1:0]   position;
        logic               position_valid;
        logic               done_res;
        logic               last;
    } t_result;

    // Request to the fraction divider: quotient = (num << FRAC_W) / den, num < den.
    typedef struct packed {
        logic               go;
        logic [DUR_W-1:0]   num;
        logic [DUR_W-1:0]   den;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [FRAC_W-1:0]  quot;
    } t_div_rsp;

endpackage

/* rtl/sli_ram.sv */
// Generic single-port-write, registered-read RAM.
module sli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sli_div.sv */
// Restoring divider producing the Q16 move fraction, one quotient bit per cycle.
module sli_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sli_pkg::t_div_req i_req,
    output sli_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(sli_pkg::FRAC_W);

    logic [sli_pkg::DUR_W-1:0]  r_rem;
    logic [sli_pkg::DUR_W-1:0]  r_den;
    logic [sli_pkg::FRAC_W-1:0] r_quot;
    logic [CNT_W-1:0]           r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [sli_pkg::DUR_W:0]    shifted;
    logic                       fits;
    logic [sli_pkg::DUR_W:0]    diff;

    // The remainder stays below the divisor, so one extra bit holds the shifted value.
    assign shifted = {r_rem, 1'b0};
    assign fits    = shifted >= {1'b0, r_den};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(sli_pkg::FRAC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.go) begin
            r_rem  <= i_req.num;
            r_den  <= i_req.den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? diff[sli_pkg::DUR_W-1:0] : shifted[sli_pkg::DUR_W-1:0];
            r_quot <= {r_quot[sli_pkg::FRAC_W-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;

endmodule

/* rtl/servo_linear_interpolator.sv */
// Top level of the servo linear interpolator: command port, sequencer and result pipeline.
//
// Usage: a command word is taken on i_cmd at a clock edge where start is high and busy
// is low. Load, start and abort words finish in that cycle and give no result, and busy
// stays low, so they may follow each other every cycle. A tick while no move is armed
// gives one result word (position_valid low, done_res and last high) in the next cycle.
// A tick during a move raises busy and gives NUM_SERVOS result words, servo 0 first,
// one per cycle on o_result marked by o_strobe; last marks the final word.
// When the tick ends the move the words carry the targets and pass through the table read,
// the registered product stage and the output register; otherwise the Q16 fraction comes
// first from a shared restoring divider, one quotient bit per cycle, and the stream starts
// once it is done. Busy drops with the final word.
// The receiver cannot stall: each word is on the port for exactly one cycle.
// The tick period register sits at APB byte address 0; pready is always high.
// Synchronous active-low reset disarms the move, sets the duration to one, clears the
// elapsed time and restores the tick period to 20 ms. The endpoint tables are not
// cleared: load each servo before the first tick.
`include "servo_linear_interpolator_macros.svh"

module servo_linear_interpolator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  sli_pkg::t_cmd                 i_cmd,
    output logic                          o_strobe,
    output sli_pkg::t_result              o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sli_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int SAW = sli_pkg::SERVO_AW;
    localparam int PW  = sli_pkg::POS_W;
    localparam logic [SAW-1:0] LAST_SERVO = SAW'(sli_pkg::NUM_SERVOS - 1);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_STREAM, S_DRAIN} t_state;

    t_state                          r_state;
    logic [sli_pkg::PERIOD_W-1:0]    r_period;
    logic [sli_pkg::DUR_W-1:0]       r_duration;
    logic [sli_pkg::ELAPSED_W-1:0]   r_elapsed;
    logic                            r_active;
    logic                            r_finish;
    logic [sli_pkg::FRAC_W-1:0]      r_t;
    logic [SAW-1:0]                  r_rd_idx;

    logic                            r_p1_vld;
    logic [SAW-1:0]                  r_p1_idx;
    logic                            r_p1_last;
    logic                            r_p2_vld;
    logic [SAW-1:0]                  r_p2_idx;
    logic                            r_p2_last;
    logic [PW-1:0]                   r_p2_start;
    logic [PW-1:0]                   r_p2_target;
    logic [PW-1:0]                   r_p2_step;

    logic                            r_strobe;
    sli_pkg::t_result                r_result;

    logic                            accept;
    logic                            cfg_wr;
    logic                            ram_we;
    logic [SAW-1:0]                  ram_waddr;
    logic [2*PW-1:0]                 ram_rdata;
    logic [PW-1:0]                   rd_start;
    logic [PW-1:0]                   rd_target;
    logic [sli_pkg::ELAPSED_W-1:0]   n_elapsed;
    logic                            ends_move;
    logic signed [PW:0]              delta;
    logic signed [2*PW+1:0]          prod;
    sli_pkg::t_div_req               div_req;
    sli_pkg::t_div_rsp               div_rsp;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == 1'b0) ? {22'd0, r_period} : 32'd0;

    // Loads addressing a servo beyond the table are dropped.
    assign ram_we    = accept && (i_cmd.operation == sli_pkg::OP_LOAD)
                       && ({28'd0, i_cmd.servo_index} < 32'(sli_pkg::NUM_SERVOS));
    assign ram_waddr = SAW'(i_cmd.servo_index);

    sli_ram #(
        .WIDTH (2 * PW),
        .DEPTH (sli_pkg::NUM_SERVOS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({i_cmd.start_pos, i_cmd.target_pos}),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_start  = ram_rdata[2*PW-1:PW];
    assign rd_target = ram_rdata[PW-1:0];

    assign n_elapsed = r_elapsed + sli_pkg::ELAPSED_W'(r_period);
    assign ends_move = n_elapsed >= {1'b0, r_duration};

    // The divisor is the stored duration; the elapsed time is below it here.
    assign div_req.go  = accept && (i_cmd.operation == sli_pkg::OP_TICK) && r_active
                         && !ends_move;
    assign div_req.num = n_elapsed[sli_pkg::DUR_W-1:0];
    assign div_req.den = r_duration;

    sli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign delta = $signed({1'b0, rd_target}) - $signed({1'b0, rd_start});
    assign prod  = delta * $signed({1'b0, r_t});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_period   <= sli_pkg::PERIOD_RESET;
            r_duration <= sli_pkg::DUR_W'(1);
            r_elapsed  <= '0;
            r_active   <= 1'b0;
            r_rd_idx   <= '0;
            r_p1_vld   <= 1'b0;
            r_p2_vld   <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            if (cfg_wr && (paddr[2] == 1'b0)) begin
                r_period <= pwdata[sli_pkg::PERIOD_W-1:0];
            end

            r_strobe <= 1'b0;
            r_p1_vld <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_cmd.operation)
                            sli_pkg::OP_LOAD: begin
                            end
                            sli_pkg::OP_START: begin
                                r_duration <= (i_cmd.move_duration == '0)
                                              ? sli_pkg::DUR_W'(1) : i_cmd.move_duration;
                                r_elapsed  <= '0;
                                r_active   <= 1'b1;
                            end
                            sli_pkg::OP_ABORT: begin
                                r_active <= 1'b0;
                            end
                            sli_pkg::OP_TICK: begin
                                if (!r_active) begin
                                    r_strobe                <= 1'b1;
                                    r_result.servo_number   <= '0;
                                    r_result.position       <= '0;
                                    r_result.position_valid <= 1'b0;
                                    r_result.done_res       <= 1'b1;
                                    r_result.last           <= 1'b1;
                                end else begin
                                    r_elapsed <= n_elapsed;
                                    r_finish  <= ends_move;
                                    r_rd_idx  <= '0;
                                    if (ends_move) begin
                                        r_active <= 1'b0;
                                        r_state  <= S_STREAM;
                                    end else begin
                                        r_state <= S_DIV;
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_t     <= div_rsp.quot;
                        r_state <= S_STREAM;
                    end
                end
                S_STREAM: begin
                    r_p1_vld  <= 1'b1;
                    r_p1_idx  <= r_rd_idx;
                    r_p1_last <= (r_rd_idx == LAST_SERVO);
                    if (r_rd_idx == LAST_SERVO) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_rd_idx <= r_rd_idx + SAW'(1);
                    end
                end
                S_DRAIN: begin
                    if (r_p2_vld && r_p2_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Table word arrives in the cycle after its address; the product is registered.
            r_p2_vld <= r_p1_vld;
            if (r_p1_vld) begin
                r_p2_idx    <= r_p1_idx;
                r_p2_last   <= r_p1_last;
                r_p2_start  <= rd_start;
                r_p2_target <= rd_target;
                r_p2_step   <= prod[2*PW-1:PW];
            end

            // Taking bits above the fraction of the signed product floors it.
            if (r_p2_vld) begin
                r_strobe                <= 1'b1;
                r_result.servo_number   <= sli_pkg::IDX_W'(r_p2_idx);
                r_result.position       <= r_finish ? r_p2_target : r_p2_start + r_p2_step;
                r_result.position_valid <= 1'b1;
                r_result.done_res       <= r_finish;
                r_result.last           <= r_p2_last;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

    `SLI_ASSERT_IMPLIES(a_idle_word, i_clk, i_rst_n,
        o_strobe && !o_result.position_valid,
        o_result.last && o_result.done_res && (o_result.position == '0),
        "idle tick word carries a position or misses its flags")
    `SLI_ASSERT_IMPLIES(a_last_frees, i_clk, i_rst_n,
        o_strobe && o_result.last, !busy,
        "block still busy when the final word of a tick leaves")
    `SLI_ASSERT_IMPLIES(a_div_in_state, i_clk, i_rst_n,
        div_rsp.done, r_state == S_DIV,
        "divider finished outside the divide phase")
    `SLI_ASSERT_NEXT(a_drain_ends, i_clk, i_rst_n,
        (r_state == S_DRAIN) && r_p2_vld && r_p2_last,
        o_strobe && o_result.last && (r_state == S_IDLE),
        "drain did not end with the final word")

endmodule

/* bench/tb.sv */
// Self-checking testbench for the servo linear interpolator: commands, ticks, period.
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_WORDS = 100;
    localparam int CALM_WORDS   = 30;
    localparam int MAX_REPORTS  = 10;
    localparam logic [sli_pkg::PADDR_W-1:0] TICK_PERIOD_ADDR = '0;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    sli_pkg::t_cmd               i_cmd = '0;
    logic                        o_strobe;
    sli_pkg::t_result            o_result;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [sli_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    // Local copy of the block's state, advanced on every accepted command word.
    logic [sli_pkg::POS_W-1:0]     start_tbl [sli_pkg::NUM_SERVOS];
    logic [sli_pkg::POS_W-1:0]     target_tbl [sli_pkg::NUM_SERVOS];
    logic [sli_pkg::DUR_W-1:0]     move_len = 16'd1;
    logic [sli_pkg::ELAPSED_W-1:0] elapsed_ms = '0;
    logic                          moving = 1'b0;
    logic [sli_pkg::PERIOD_W-1:0]  period_ms = sli_pkg::PERIOD_RESET;

    sli_pkg::t_result pending_positions [$];
    int      mismatch_count = 0;
    int      words_sent = 0;
    int      cycle_count = 0;
    logic    sender_gaps_on = 1'b1;

    servo_linear_interpolator dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected",
                     cycle_count, pending_positions.size());
            $display("[servo_linear_interpolator] ERROR");
            $finish;
        end
    end

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v)
            note_mismatch($sformatf("%s expected %0h got %0h", name, exp_v, act_v));
    endtask

    // Every strobed word is matched against the oldest predicted word.
    always @(posedge i_clk) begin
        sli_pkg::t_result want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_positions.size() == 0) begin
                note_mismatch($sformatf("unexpected word %p", o_result));
            end else begin
                want = pending_positions.pop_front();
                check_field("servo_number", want.servo_number, o_result.servo_number);
                check_field("position", want.position, o_result.position);
                check_field("position_valid", want.position_valid, o_result.position_valid);
                check_field("done_res", want.done_res, o_result.done_res);
                check_field("last", want.last, o_result.last);
            end
        end
    end

    function automatic void predict_command(input sli_pkg::t_cmd c);
        sli_pkg::t_result           r;
        logic [sli_pkg::FRAC_W-1:0] frac;
        longint                     delta;
        longint                     prod;
        if (c.operation == sli_pkg::OP_LOAD) begin
            if (c.servo_index < sli_pkg::NUM_SERVOS) begin
                start_tbl[c.servo_index]  = c.start_pos;
                target_tbl[c.servo_index] = c.target_pos;
            end
        end else if (c.operation == sli_pkg::OP_START) begin
            move_len   = (c.move_duration == '0) ? 16'd1 : c.move_duration;
            elapsed_ms = '0;
            moving     = 1'b1;
        end else if (c.operation == sli_pkg::OP_ABORT) begin
            moving = 1'b0;
        end else if (!moving) begin
            r = '0;
            r.done_res = 1'b1;
            r.last     = 1'b1;
            pending_positions.push_back(r);
        end else begin
            elapsed_ms = elapsed_ms + sli_pkg::ELAPSED_W'(period_ms);
            if (elapsed_ms >= sli_pkg::ELAPSED_W'(move_len)) begin
                moving = 1'b0;
                for (int i = 0; i < sli_pkg::NUM_SERVOS; i++) begin
                    r.servo_number   = sli_pkg::IDX_W'(i);
                    r.position       = target_tbl[i];
                    r.position_valid = 1'b1;
                    r.done_res       = 1'b1;
                    r.last           = (i == sli_pkg::NUM_SERVOS - 1);
                    pending_positions.push_back(r);
                end
            end else begin
                // Q16 fraction of the move; the signed shift rounds toward minus infinity.
                frac = sli_pkg::FRAC_W'({elapsed_ms, 16'b0} / move_len);
                for (int i = 0; i < sli_pkg::NUM_SERVOS; i++) begin
                    delta = longint'(target_tbl[i]) - longint'(start_tbl[i]);
                    prod  = delta * longint'(frac);
                    r.servo_number   = sli_pkg::IDX_W'(i);
                    r.position       = sli_pkg::POS_W'(longint'(start_tbl[i]) + (prod >>> 16));
                    r.position_valid = 1'b1;
                    r.done_res       = 1'b0;
                    r.last           = (i == sli_pkg::NUM_SERVOS - 1);
                    pending_positions.push_back(r);
                end
            end
        end
    endfunction

    // Called at a clock edge; returns at the edge where the word was taken.
    task automatic send_word(input sli_pkg::t_cmd c);
        if (sender_gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_command(c);
        words_sent++;
    endtask

    task automatic send_load(input logic [sli_pkg::IDX_W-1:0] idx,
                             input logic [sli_pkg::POS_W-1:0] from_pos,
                             input logic [sli_pkg::POS_W-1:0] to_pos);
        sli_pkg::t_cmd c;
        c = '0;
        c.operation     = sli_pkg::OP_LOAD;
        c.servo_index   = idx;
        c.start_pos     = from_pos;
        c.target_pos    = to_pos;
        c.move_duration = sli_pkg::DUR_W'($urandom());
        send_word(c);
    endtask

    task automatic send_start(input logic [sli_pkg::DUR_W-1:0] dur);
        sli_pkg::t_cmd c;
        c = '0;
        c.operation     = sli_pkg::OP_START;
        c.servo_index   = sli_pkg::IDX_W'($urandom());
        c.move_duration = dur;
        send_word(c);
    endtask

    task automatic send_op(input sli_pkg::t_op op);
        sli_pkg::t_cmd c;
        c = '0;
        c.operation = op;
        send_word(c);
    endtask

    task automatic send_random_load();
        send_load(sli_pkg::IDX_W'($urandom()), sli_pkg::POS_W'($urandom()),
                  sli_pkg::POS_W'($urandom()));
    endtask

    // Lets every expected word arrive and the block settle before a register access.
    task automatic drain();
        start <= 1'b0;
        while (pending_positions.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic read_period();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= TICK_PERIOD_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== 32'(period_ms))
            note_mismatch($sformatf("tick period read expected %0d got %0h",
                                    period_ms, prdata));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Upper data bits are random: only the low PERIOD_W bits land in the register.
    // The read that follows starts its setup phase right after the write's access phase.
    task automatic set_period(input logic [sli_pkg::PERIOD_W-1:0] p);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TICK_PERIOD_ADDR;
        pwdata  <= ($urandom() & 32'hFFFF_FC00) | 32'(p);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        period_ms = p;
        read_period();
    endtask

    function automatic logic [sli_pkg::DUR_W-1:0] pick_duration();
        int unsigned d;
        if ($urandom_range(0, 3) == 0 || period_ms == '0)
            return sli_pkg::DUR_W'($urandom());
        d = period_ms * $urandom_range(1, 6) + $urandom_range(0, period_ms);
        return (d > 65535) ? 16'hFFFF : sli_pkg::DUR_W'(d);
    endfunction

    task automatic test_reset_value();
        read_period();
    endtask

    task automatic test_directed();
        // Servos 0 to 3 get every pairing of the range ends, the rest random endpoints.
        for (int i = 0; i < sli_pkg::NUM_SERVOS; i++) begin
            if (i < 4)
                send_load(sli_pkg::IDX_W'(i), i[0] ? 16'hFFFF : 16'h0000,
                          i[1] ? 16'hFFFF : 16'h0000);
            else
                send_load(sli_pkg::IDX_W'(i), sli_pkg::POS_W'($urandom()),
                          sli_pkg::POS_W'($urandom()));
        end
        send_op(sli_pkg::OP_TICK);
        send_op(sli_pkg::OP_ABORT);
        send_start(16'd0);
        send_op(sli_pkg::OP_TICK);
        send_start(16'hFFFF);
        send_op(sli_pkg::OP_TICK);
        send_load(4'd5, 16'hFFFF, 16'h0001);
        send_op(sli_pkg::OP_TICK);
        send_start(16'd50);
        send_op(sli_pkg::OP_TICK);
        send_op(sli_pkg::OP_TICK);
        send_op(sli_pkg::OP_TICK);
        send_op(sli_pkg::OP_TICK);
    endtask

    task automatic test_period_extremes();
        // A zero period freezes the move at its start positions.
        set_period('0);
        send_start(16'd100);
        repeat (3) send_op(sli_pkg::OP_TICK);
        send_op(sli_pkg::OP_ABORT);
        send_op(sli_pkg::OP_TICK);
        set_period(10'd1);
        send_start(16'd3);
        repeat (3) send_op(sli_pkg::OP_TICK);
        set_period(10'd1023);
        send_start(16'hFFFF);
        repeat (2) send_op(sli_pkg::OP_TICK);
        send_op(sli_pkg::OP_ABORT);
        send_start(16'd5000);
        repeat (5) send_op(sli_pkg::OP_TICK);
    endtask

    task automatic run_move();
        int ticks;
        repeat ($urandom_range(0, 3)) send_random_load();
        send_start(pick_duration());
        ticks = 0;
        while (moving && ticks < 12) begin
            case ($urandom_range(0, 11))
                0: send_random_load();
                1: send_op(sli_pkg::OP_ABORT);
                2: send_start(pick_duration());
                default: send_op(sli_pkg::OP_TICK);
            endcase
            ticks++;
        end
        if (moving)
            send_op(sli_pkg::OP_ABORT);
    endtask

    task automatic test_random();
        int base;
        logic [$bits(sli_pkg::t_cmd)-1:0] raw;
        base = words_sent;
        while (words_sent - base < RANDOM_WORDS) begin
            sender_gaps_on = (words_sent - base < RANDOM_WORDS - CALM_WORDS) &&
                             ($urandom_range(0, 2) != 0);
            case ($urandom_range(0, 11))
                0: begin
                    raw = $bits(sli_pkg::t_cmd)'({$urandom(), $urandom()});
                    send_word(sli_pkg::t_cmd'(raw));
                end
                1: begin
                    if (!sender_gaps_on)
                        run_move();
                    else
                        case ($urandom_range(0, 4))
                            0: set_period(10'd1);
                            1: set_period(10'd1023);
                            2: set_period(sli_pkg::PERIOD_RESET);
                            3: set_period(($urandom_range(0, 3) == 0) ? 10'd0 : 10'd7);
                            default: set_period(sli_pkg::PERIOD_W'($urandom_range(1, 1023)));
                        endcase
                end
                default: run_move();
            endcase
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_value();
        test_directed();
        test_period_extremes();
        test_random();
        drain();
        if (mismatch_count == 0)
            $display("[servo_linear_interpolator] OK");
        else
            $display("[servo_linear_interpolator] ERROR");
        $finish;
    end

endmodule
